FILE: hdl/ils_pkg.sv
// shared action and status codes, field widths and the cell command type
package ils_pkg;

    localparam int ACT_W  = 3;
    localparam int POS_W  = 7;
    localparam int DATA_W = 32;
    localparam int STAT_W = 2;
    localparam int FPOS_W = 6;
    localparam int CNT_W  = 7;

    localparam int S_TDATA_W = 40;
    localparam int M_TDATA_W = 56;

    localparam logic [ACT_W-1:0] ACT_APPEND = 3'd0;
    localparam logic [ACT_W-1:0] ACT_INSERT = 3'd1;
    localparam logic [ACT_W-1:0] ACT_READ   = 3'd2;
    localparam logic [ACT_W-1:0] ACT_WRITE  = 3'd3;
    localparam logic [ACT_W-1:0] ACT_REMOVE = 3'd4;
    localparam logic [ACT_W-1:0] ACT_FIND   = 3'd5;
    localparam logic [ACT_W-1:0] ACT_CLEAR  = 3'd6;

    localparam logic [STAT_W-1:0] ST_OK      = 2'd0;
    localparam logic [STAT_W-1:0] ST_BAD_POS = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL    = 2'd2;

    typedef struct packed {
        logic capture;
        logic append;
        logic insert;
        logic write;
        logic remove;
        logic search;
        logic select;
    } t_cell_cmd;

endpackage

FILE: hdl/ils_cell.sv
// one list slot: holds an entry, shifts with its neighbors, compares and selects
module ils_cell import ils_pkg::*; #(
    parameter int INDEX = 0,
    parameter int PW    = 7,
    parameter int CW    = 7,
    parameter int EW    = 32
) (
    input  logic          i_clk,
    input  t_cell_cmd     i_cmd,
    input  logic [PW-1:0] i_pos,
    input  logic [CW-1:0] i_count,
    input  logic [EW-1:0] i_elem,
    input  logic [EW-1:0] i_left,
    input  logic [EW-1:0] i_right,
    output logic [EW-1:0] o_val,
    output logic          o_match,
    output logic [EW-1:0] o_sel
);

    localparam logic [PW-1:0] IDX_P = PW'(INDEX);
    localparam logic [CW-1:0] IDX_C = CW'(INDEX);

    logic [EW-1:0] r_val;
    logic [EW-1:0] n_val;
    logic          r_match;
    logic [EW-1:0] r_sel;

    always_comb begin
        n_val = r_val;
        if (i_cmd.capture) begin
            if (i_cmd.append && IDX_C == i_count) begin
                n_val = i_elem;
            end
            if (i_cmd.insert) begin
                if (IDX_P == i_pos) begin
                    n_val = i_elem;
                end else if (IDX_P > i_pos) begin
                    n_val = i_left;
                end
            end
            if (i_cmd.write && IDX_P == i_pos) begin
                n_val = i_elem;
            end
            if (i_cmd.remove && IDX_P >= i_pos) begin
                n_val = i_right;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_val <= n_val;
        if (i_cmd.capture) begin
            // compare and select see the entry as it was before this item
            r_match <= i_cmd.search && (IDX_C < i_count) && (r_val == i_elem);
            r_sel   <= (i_cmd.select && IDX_P == i_pos) ? r_val : '0;
        end
    end

    assign o_val   = r_val;
    assign o_match = r_match;
    assign o_sel   = r_sel;

endmodule

FILE: hdl/ils_pick.sv
// first-match encoder and or-merge of the selected entry across the cell row
module ils_pick import ils_pkg::*; #(
    parameter int N  = 64,
    parameter int IW = 6,
    parameter int EW = 32
) (
    input  logic [N-1:0]  i_match,
    input  logic [EW-1:0] i_sel [N],
    output logic          o_found,
    output logic [IW-1:0] o_pos,
    output logic [EW-1:0] o_elem
);

    logic [N-1:0] w_first;

    // isolate the lowest set match bit
    assign w_first = i_match & (~i_match + N'(1));
    assign o_found = |i_match;

    always_comb begin
        o_pos  = '0;
        o_elem = '0;
        for (int k = 0; k < N; k++) begin
            if (w_first[k]) begin
                o_pos = o_pos | IW'(k);
            end
            o_elem = o_elem | i_sel[k];
        end
    end

endmodule

FILE: hdl/indexed_list_store_top.sv
// ordered list of element handles built as a shifting row of cells
// On accept every cell shifts, loads or compares at once and registers what it holds; then,
// once the output register is free or being emptied, the first-match encoder and entry select
// over the whole row fill it. A new item is taken in the cycle after that fill, even while the
// previous result still waits on the output side. The action travels in s_axis_tuser; a bad
// position is checked before a full list, and a failed action leaves the list unchanged.
module indexed_list_store_top import ils_pkg::*; #(
    parameter int CAPACITY   = 64,
    parameter int ELEM_WIDTH = 32
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [S_TDATA_W-1:0] s_axis_tdata,  // position[6:0], element[38:7], zero[39]
    input  logic [ACT_W-1:0]     s_axis_tuser,  // action[2:0]
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [M_TDATA_W-1:0] m_axis_tdata   // status[1:0], element_out[33:2], found[34],
                                                // found_position[40:35], entry_count[47:41],
                                                // is_empty[48], zero[55:49]
);

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int PW = (CW > POS_W) ? CW : POS_W;
    localparam int IW = $clog2(CAPACITY);
    localparam int EW = ELEM_WIDTH;

    logic [ACT_W-1:0]  w_act;
    logic [POS_W-1:0]  w_pos7;
    logic [DATA_W-1:0] w_elem32;
    logic [63:0]       w_elem64;
    logic [EW-1:0]     w_elem;
    logic [PW-1:0]     w_pos;
    logic [PW-1:0]     w_cnt_p;
    logic              w_accept;
    logic              w_emit;
    logic              w_bad;
    logic              w_full;
    logic              w_ok;
    logic [STAT_W-1:0] w_status;
    logic [CW-1:0]     n_count;
    t_cell_cmd         w_cmd;

    logic                 r_busy;
    logic [CW-1:0]        r_count;
    logic [STAT_W-1:0]    r_status;
    logic                 r_out_valid;
    logic [M_TDATA_W-1:0] r_out_data;
    logic [M_TDATA_W-1:0] n_out_data;

    logic [EW-1:0]       w_val   [CAPACITY];
    logic [EW-1:0]       w_sel   [CAPACITY];
    logic [CAPACITY-1:0] w_match;

    logic              w_found;
    logic [IW-1:0]     w_fpos;
    logic [EW-1:0]     w_pick;
    logic [63:0]       w_pick64;
    logic [31:0]       w_fpos32;
    logic [31:0]       w_cnt32;

    assign w_act    = s_axis_tuser;
    assign w_pos7   = s_axis_tdata[POS_W-1:0];
    assign w_elem32 = s_axis_tdata[POS_W+DATA_W-1:POS_W];
    assign w_elem64 = 64'(w_elem32);
    assign w_elem   = w_elem64[EW-1:0];
    assign w_pos    = PW'(w_pos7);
    assign w_cnt_p  = PW'(r_count);
    assign w_accept = s_axis_tvalid && s_axis_tready;

    always_comb begin
        w_bad  = 1'b0;
        w_full = 1'b0;
        case (w_act)
            ACT_APPEND: begin
                w_full = (r_count == CW'(CAPACITY));
            end
            ACT_INSERT: begin
                w_bad  = (w_pos > w_cnt_p);
                w_full = (r_count == CW'(CAPACITY));
            end
            ACT_READ, ACT_WRITE, ACT_REMOVE: begin
                w_bad = (w_pos >= w_cnt_p);
            end
            default: begin
            end
        endcase
    end

    assign w_ok     = !w_bad && !w_full;
    assign w_status = w_bad ? ST_BAD_POS : (w_full ? ST_FULL : ST_OK);

    always_comb begin
        n_count = r_count;
        w_cmd   = '0;
        w_cmd.capture = w_accept;
        case (w_act)
            ACT_APPEND: begin
                w_cmd.append = w_ok;
                if (w_ok) begin
                    n_count = r_count + CW'(1);
                end
            end
            ACT_INSERT: begin
                w_cmd.insert = w_ok;
                if (w_ok) begin
                    n_count = r_count + CW'(1);
                end
            end
            ACT_READ: begin
                w_cmd.select = w_ok;
            end
            ACT_WRITE: begin
                w_cmd.write = w_ok;
            end
            ACT_REMOVE: begin
                w_cmd.remove = w_ok;
                w_cmd.select = w_ok;
                if (w_ok) begin
                    n_count = r_count - CW'(1);
                end
            end
            ACT_FIND: begin
                w_cmd.search = 1'b1;
            end
            ACT_CLEAR: begin
                n_count = '0;
            end
            default: begin
            end
        endcase
    end

    genvar gi;
    generate
        for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
            logic [EW-1:0] w_left;
            logic [EW-1:0] w_right;
            if (gi == 0) begin : g_first
                assign w_left = '0;
            end else begin : g_mid_l
                assign w_left = w_val[gi-1];
            end
            if (gi == CAPACITY - 1) begin : g_last
                assign w_right = w_val[gi];
            end else begin : g_mid_r
                assign w_right = w_val[gi+1];
            end
            ils_cell #(
                .INDEX (gi),
                .PW    (PW),
                .CW    (CW),
                .EW    (EW)
            ) u_cell (
                .i_clk   (i_clk),
                .i_cmd   (w_cmd),
                .i_pos   (w_pos),
                .i_count (r_count),
                .i_elem  (w_elem),
                .i_left  (w_left),
                .i_right (w_right),
                .o_val   (w_val[gi]),
                .o_match (w_match[gi]),
                .o_sel   (w_sel[gi])
            );
        end
    endgenerate

    ils_pick #(
        .N  (CAPACITY),
        .IW (IW),
        .EW (EW)
    ) u_pick (
        .i_match (w_match),
        .i_sel   (w_sel),
        .o_found (w_found),
        .o_pos   (w_fpos),
        .o_elem  (w_pick)
    );

    assign w_pick64 = 64'(w_pick);
    assign w_fpos32 = 32'(w_fpos);
    assign w_cnt32  = 32'(r_count);

    assign n_out_data = {7'b0, (r_count == '0), w_cnt32[CNT_W-1:0], w_fpos32[FPOS_W-1:0],
                         w_found, w_pick64[DATA_W-1:0], r_status};

    // result moves on once the output register is free or being emptied
    assign w_emit = r_busy && (!r_out_valid || m_axis_tready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_accept) begin
                r_busy  <= 1'b1;
                r_count <= n_count;
            end else if (w_emit) begin
                r_busy <= 1'b0;
            end
            if (w_emit) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_status <= w_status;
        end
        if (w_emit) begin
            r_out_data <= n_out_data;
        end
    end

    // no item is taken while reset is held
    assign s_axis_tready = i_rst_n && !r_busy;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

endmodule

FILE: hdl/ils_checker.sv
// port-level checks on the list store, bound to the top level
module ils_port_checks import ils_pkg::*; (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 s_axis_tvalid,
    input logic                 s_axis_tready,
    input logic [S_TDATA_W-1:0] s_axis_tdata,
    input logic [ACT_W-1:0]     s_axis_tuser,
    input logic                 m_axis_tvalid,
    input logic                 m_axis_tready,
    input logic [M_TDATA_W-1:0] m_axis_tdata
);

    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid right after reset");

    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("item taken while another is in work");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result changed");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[1:0] != 2'd3)
        else $error("unknown status code");

    a_found_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[34] |-> m_axis_tdata[1:0] == ST_OK &&
            m_axis_tdata[33:2] == 32'd0)
        else $error("find result carries status or element");

endmodule

bind indexed_list_store_top ils_port_checks u_ils_port_checks (.*);

FILE: tb/ils_checker.sv
// scoreboard for the list store: mirrors the list and checks every result item
module ils_checker import ils_pkg::*; #(
    parameter int CAPACITY   = 64,
    parameter int ELEM_WIDTH = 32
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 s_axis_tvalid,
    input  logic                 s_axis_tready,
    input  logic [S_TDATA_W-1:0] s_axis_tdata,  // position[6:0], element[38:7], zero[39]
    input  logic [ACT_W-1:0]     s_axis_tuser,  // action[2:0]
    input  logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    input  logic [M_TDATA_W-1:0] m_axis_tdata,  // status[1:0], element_out[33:2], found[34],
                                                // found_position[40:35], entry_count[47:41],
                                                // is_empty[48], zero[55:49]
    output int                   o_fail_count,
    output int                   o_outstanding,
    output int                   o_list_len,
    output int                   o_checked
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [DATA_W-1:0] ELEM_MASK =
        DATA_W'((ELEM_WIDTH >= 64) ? ~64'd0 : (64'd1 << ELEM_WIDTH) - 64'd1);

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [DATA_W-1:0] elem_out;
        logic              found;
        logic [FPOS_W-1:0] found_pos;
        logic [CNT_W-1:0]  count;
        logic              empty;
    } t_list_result;

    logic [DATA_W-1:0] list_mem [CAPACITY];
    int                list_len;
    t_list_result      pending_q [$];
    int                mismatch_total;
    int                checked_total;

    // apply one action to the mirrored list and return the result it should give
    function automatic t_list_result apply_action(input logic [ACT_W-1:0] act,
                                                  input logic [POS_W-1:0] pos,
                                                  input logic [DATA_W-1:0] elem_in);
        t_list_result      r;
        logic [DATA_W-1:0] elem;
        int                p;
        int                i;
        r    = '0;
        elem = elem_in & ELEM_MASK;
        p    = pos;
        case (act)
            ACT_APPEND: begin
                if (list_len >= CAPACITY) begin
                    r.status = ST_FULL;
                end else begin
                    list_mem[list_len] = elem;
                    list_len++;
                end
            end
            ACT_INSERT: begin
                // position is checked before fullness
                if (p > list_len) begin
                    r.status = ST_BAD_POS;
                end else if (list_len >= CAPACITY) begin
                    r.status = ST_FULL;
                end else begin
                    for (i = list_len; i > p; i--)
                        list_mem[i] = list_mem[i-1];
                    list_mem[p] = elem;
                    list_len++;
                end
            end
            ACT_READ: begin
                if (p >= list_len || p >= CAPACITY)
                    r.status = ST_BAD_POS;
                else
                    r.elem_out = list_mem[p];
            end
            ACT_WRITE: begin
                if (p >= list_len || p >= CAPACITY)
                    r.status = ST_BAD_POS;
                else
                    list_mem[p] = elem;
            end
            ACT_REMOVE: begin
                if (p >= list_len || p >= CAPACITY) begin
                    r.status = ST_BAD_POS;
                end else begin
                    r.elem_out = list_mem[p];
                    for (i = p; i + 1 < list_len; i++)
                        list_mem[i] = list_mem[i+1];
                    list_len--;
                end
            end
            ACT_FIND: begin
                for (i = 0; i < list_len && i < CAPACITY; i++) begin
                    if (!r.found && list_mem[i] == elem) begin
                        r.found     = 1'b1;
                        r.found_pos = i[FPOS_W-1:0];
                    end
                end
            end
            ACT_CLEAR: begin
                list_len = 0;
            end
            default: begin
                // unused code leaves the list alone
            end
        endcase
        r.count = list_len[CNT_W-1:0];
        r.empty = (list_len == 0);
        return r;
    endfunction

    task automatic check_field(input string what, input logic [DATA_W-1:0] want,
                               input logic [DATA_W-1:0] got);
        if (want !== got) begin
            $display("%0t mismatch in %s: expected %h actual %h", $time, what, want, got);
            mismatch_total++;
        end
    endtask

    always @(posedge i_clk) begin : scoreboard
        t_list_result want;
        t_list_result got;
        if (!i_rst_n) begin
            list_len       = 0;
            mismatch_total = 0;
            checked_total  = 0;
            pending_q.delete();
        end else begin
            // retire the oldest expectation before queuing a new one
            if (m_axis_tvalid && m_axis_tready) begin
                got.status    = m_axis_tdata[1:0];
                got.elem_out  = m_axis_tdata[33:2];
                got.found     = m_axis_tdata[34];
                got.found_pos = m_axis_tdata[40:35];
                got.count     = m_axis_tdata[47:41];
                got.empty     = m_axis_tdata[48];
                if (pending_q.size() == 0) begin
                    $display("%0t unexpected result item: expected none actual %h",
                             $time, m_axis_tdata);
                    mismatch_total++;
                end else begin
                    want = pending_q.pop_front();
                    check_field("status", want.status, got.status);
                    check_field("element_out", want.elem_out, got.elem_out);
                    check_field("found", want.found, got.found);
                    check_field("found_position", want.found_pos, got.found_pos);
                    check_field("entry_count", want.count, got.count);
                    check_field("is_empty", want.empty, got.empty);
                    checked_total++;
                end
            end
            if (s_axis_tvalid && s_axis_tready)
                pending_q.push_back(apply_action(s_axis_tuser, s_axis_tdata[6:0],
                                                 s_axis_tdata[38:7]));
        end
        o_fail_count  <= mismatch_total;
        o_outstanding <= pending_q.size();
        o_list_len    <= list_len;
        o_checked     <= checked_total;
    end

endmodule

FILE: tb/tb_top.sv
// testbench top: drives list actions into the store and reports the verdict
module tb_top import ils_pkg::*;;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int               LIST_CAP     = 64;
    localparam int               ELEM_BITS    = 32;
    localparam logic [ACT_W-1:0] ACT_UNUSED   = 3'd7;
    localparam int               RANDOM_ITEMS = 1850;
    localparam int               DRAIN_LIMIT  = 10000;

    logic                 i_clk         = 1'b0;
    logic                 i_rst_n       = 1'b0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [S_TDATA_W-1:0] s_axis_tdata  = '0;  // position[6:0], element[38:7], zero[39]
    logic [ACT_W-1:0]     s_axis_tuser  = '0;  // action[2:0]
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_axis_tdata;  // status[1:0], element_out[33:2], found[34],
                                         // found_position[40:35], entry_count[47:41],
                                         // is_empty[48], zero[55:49]

    logic              steady = 1'b0;  // no idling on either side while set
    int                fail_count;
    int                outstanding;
    int                list_len;
    int                checked;
    int                sent_by_act [8];
    logic [DATA_W-1:0] pool [16];

    indexed_list_store_top #(
        .CAPACITY   (LIST_CAP),
        .ELEM_WIDTH (ELEM_BITS)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    ils_checker #(
        .CAPACITY   (LIST_CAP),
        .ELEM_WIDTH (ELEM_BITS)
    ) u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .o_fail_count  (fail_count),
        .o_outstanding (outstanding),
        .o_list_len    (list_len),
        .o_checked     (checked)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        m_axis_tready <= steady ? 1'b1 : ($urandom_range(99) >= 35);
    end

    initial begin
        #2_000_000;
        $display("FAIL indexed_list_store_top");
        $finish;
    end

    task automatic send_item(input logic [ACT_W-1:0] act, input logic [POS_W-1:0] pos,
                             input logic [DATA_W-1:0] elem);
        while (!steady && $urandom_range(99) < 35) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {1'b0, elem, pos};
        s_axis_tuser  <= act;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        sent_by_act[act]++;
    endtask

    // hold the input side until every queued result item has come back or the limit runs out
    task automatic wait_drained(input int limit);
        int waited;
        waited = 0;
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (outstanding != 0 && waited < limit) begin
            @(posedge i_clk);
            waited++;
        end
    endtask

    // half the handles come from a small pool so finds hit and duplicates occur
    function automatic logic [DATA_W-1:0] pick_elem();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 50)
            return pool[$urandom_range(15)];
        if (r < 56)
            return '0;
        if (r < 62)
            return '1;
        return $urandom;
    endfunction

    // mode 0 grows the list, mode 1 shrinks it, anything else mixes
    function automatic logic [ACT_W-1:0] pick_action(input int mode);
        int unsigned cut [7];
        int unsigned r;
        case (mode)
            0:       cut = '{40, 70, 76, 82, 88, 96, 97};
            1:       cut = '{10, 20, 30, 38, 86, 94, 97};
            default: cut = '{18, 34, 48, 60, 76, 92, 96};
        endcase
        r = $urandom_range(99);
        if (r < cut[0]) return ACT_APPEND;
        if (r < cut[1]) return ACT_INSERT;
        if (r < cut[2]) return ACT_READ;
        if (r < cut[3]) return ACT_WRITE;
        if (r < cut[4]) return ACT_REMOVE;
        if (r < cut[5]) return ACT_FIND;
        if (r < cut[6]) return ACT_CLEAR;
        return ACT_UNUSED;
    endfunction

    function automatic logic [POS_W-1:0] pick_pos(input logic [ACT_W-1:0] act);
        int               top_pos;
        int unsigned      r;
        logic [POS_W-1:0] p;
        r = $urandom_range(99);
        top_pos = (act == ACT_INSERT) ? list_len : list_len - 1;
        if (top_pos < 0)
            top_pos = 0;
        if (r < 12)
            p = POS_W'($urandom_range((1 << POS_W) - 1));
        else if (r < 17)
            p = POS_W'(list_len + 1);  // just past the valid range for an insert
        else
            p = POS_W'($urandom_range(top_pos));
        return p;
    endfunction

    initial begin : stimulus
        logic [ACT_W-1:0] act;
        int               i;
        int               mode;
        mode = 2;
        for (i = 0; i < 16; i++)
            pool[i] = $urandom;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // empty list corner cases
        send_item(ACT_READ,   0, 32'h0000_0000);
        send_item(ACT_REMOVE, 0, 32'h0000_0000);
        send_item(ACT_FIND,   0, 32'h0000_0000);
        send_item(ACT_INSERT, 1, 32'h0000_0000);
        send_item(ACT_WRITE,  0, 32'hFFFF_FFFF);
        // build 0, 5a5aa5a5, ffffffff, a5a55a5a
        send_item(ACT_INSERT, 0, 32'h0000_0000);
        send_item(ACT_APPEND, 0, 32'hFFFF_FFFF);
        send_item(ACT_INSERT, 2, 32'hA5A5_5A5A);
        send_item(ACT_INSERT, 1, 32'h5A5A_A5A5);
        send_item(ACT_READ,   0, 32'h0000_0000);
        send_item(ACT_READ,   3, 32'h0000_0000);
        send_item(ACT_WRITE,  3, 32'h0000_0001);
        send_item(ACT_FIND,   0, 32'hFFFF_FFFF);
        // duplicate handle: find must report the first one
        send_item(ACT_APPEND, 0, 32'h0000_0000);
        send_item(ACT_FIND,   0, 32'h0000_0000);
        send_item(ACT_FIND,   0, 32'h1234_5678);
        send_item(ACT_UNUSED, 127, 32'hFFFF_FFFF);
        send_item(ACT_READ,   127, 32'h0000_0000);
        send_item(ACT_WRITE,  POS_W'(LIST_CAP), 32'hFFFF_FFFF);
        send_item(ACT_REMOVE, 1, 32'h0000_0000);
        send_item(ACT_REMOVE, 3, 32'h0000_0000);
        send_item(ACT_INSERT, 4, 32'h0000_0000);
        send_item(ACT_CLEAR,  0, 32'h0000_0000);
        send_item(ACT_READ,   0, 32'h0000_0000);

        // fill to capacity with random handles, then push on the full list
        send_item(ACT_CLEAR, 0, 32'h0000_0000);
        repeat (LIST_CAP) send_item(ACT_APPEND, 0, pick_elem());
        send_item(ACT_APPEND, 0, pick_elem());
        send_item(ACT_INSERT, POS_W'(LIST_CAP), pick_elem());
        send_item(ACT_INSERT, 0, pick_elem());
        send_item(ACT_INSERT, POS_W'(LIST_CAP + 1), pick_elem());
        send_item(ACT_READ,   POS_W'(LIST_CAP - 1), 32'h0000_0000);
        send_item(ACT_READ,   POS_W'(LIST_CAP), 32'h0000_0000);
        send_item(ACT_FIND,   0, pool[0]);
        send_item(ACT_REMOVE, POS_W'(LIST_CAP - 1), 32'h0000_0000);
        send_item(ACT_INSERT, POS_W'(LIST_CAP - 1), pick_elem());

        for (i = 0; i < RANDOM_ITEMS; i++) begin
            if (i % 64 == 0)
                mode = $urandom_range(2);
            if (i == 700)
                steady <= 1'b1;
            if (i == 1000)
                steady <= 1'b0;
            if (i == 500 || i == 1300)
                wait_drained(DRAIN_LIMIT);
            act = pick_action(mode);
            send_item(act, pick_pos(act), pick_elem());
        end

        wait_drained(DRAIN_LIMIT);
        repeat (20) @(posedge i_clk);
        $display("covered %0d append, %0d insert, %0d read, %0d write, %0d remove, %0d find,",
                 sent_by_act[ACT_APPEND], sent_by_act[ACT_INSERT], sent_by_act[ACT_READ],
                 sent_by_act[ACT_WRITE], sent_by_act[ACT_REMOVE], sent_by_act[ACT_FIND]);
        $display("%0d clear and %0d unused-code items; %0d result items compared",
                 sent_by_act[ACT_CLEAR], sent_by_act[ACT_UNUSED], checked);
        if (outstanding != 0)
            $display("%0t %0d expected result items never arrived", $time, outstanding);
        if (fail_count == 0 && outstanding == 0)
            $display("PASS indexed_list_store_top");
        else
            $display("FAIL indexed_list_store_top");
        $finish;
    end

endmodule
